/* sv/grid_outline_segment_extractor_unit_assert.svh */
// grid_outline_segment_extractor_unit_assert.svh: assertion macros shared by the
// segment extractor modules; needs nothing else
`ifndef GRID_OUTLINE_SEGMENT_EXTRACTOR_UNIT_ASSERT_SVH
`define GRID_OUTLINE_SEGMENT_EXTRACTOR_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define GOSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gose assertion failed");

// condition holds in the cycle after the trigger
`define GOSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gose assertion failed");

`endif

/* sv/gose_pkg.sv */
// gose_pkg: types and constants of the grid outline segment extractor
// used by gose_scan, gose_emit and the top level; depends on nothing
`default_nettype none

package gose_pkg;

    localparam int COORD_W    = 17;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X     = 2'd0,
        CFG_ORIGIN_Y     = 2'd1,
        CFG_GRID_COLUMNS = 2'd2,
        CFG_GRID_ROWS    = 2'd3
    } cfg_reg_t;

    // one cell's worth of segments, handed from the scan stage to the emitter
    typedef struct packed {
        logic   vert;
        logic   horz;
        logic   final_pos;
        coord_t x0;
        coord_t x1;
        coord_t y0;
        coord_t y1;
    } seg_item_t;

endpackage

`default_nettype wire

/* sv/gose_ram.sv */
// gose_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module gose_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/gose_scan.sv */
// gose_scan: scan position, line buffer with fill count, neighbor compare and
// coordinate build; uses gose_pkg and gose_ram
`default_nettype none
`include "grid_outline_segment_extractor_unit_assert.svh"

module gose_scan #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [15:0] origin_x,
    input  wire logic signed [15:0] origin_y,
    input  wire logic        [6:0]  grid_columns,
    input  wire logic        [6:0]  grid_rows,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               occupied,
    output logic                    item_valid,
    output gose_pkg::seg_item_t     item,
    input  wire logic               item_ready
);
    import gose_pkg::*;

    localparam int DEPTH = MAX_COLUMNS + 1;
    localparam int CW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          left_reg, left_next;
    logic          primed_reg;
    logic          item_valid_reg, item_valid_next;
    seg_item_t     item_reg, item_next;

    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          accept;
    logic          ram_rdata;
    logic          left_cell, below_cell;
    logic          col_end, row_end;
    coord_t        ox, oy;

    // clamp the configured size into 1..max
    always_comb begin
        if (grid_columns == 7'd0) begin
            last_col = CW'(1);
        end else if (32'(grid_columns) > 32'(MAX_COLUMNS)) begin
            last_col = CW'(MAX_COLUMNS);
        end else begin
            last_col = CW'(grid_columns);
        end
        if (grid_rows == 7'd0) begin
            last_row = RW'(1);
        end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
            last_row = RW'(MAX_ROWS);
        end else begin
            last_row = RW'(grid_rows);
        end
    end

    // read data of the current column is ready in the cycle after the address settles
    assign s_tready = primed_reg && (!item_valid_reg || item_ready);
    assign accept   = s_tvalid && s_tready;

    gose_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (occupied),
        .rd_addr (col_reg),
        .rd_data (ram_rdata)
    );

    // columns beyond the fill count were never written and read as empty
    assign left_cell  = (col_reg != '0) && left_reg;
    assign below_cell = (row_reg != '0) && (FW'(col_reg) < fill_reg) && ram_rdata;
    assign col_end    = col_reg >= last_col;
    assign row_end    = row_reg >= last_row;
    assign ox         = coord_t'({origin_x[15], origin_x});
    assign oy         = coord_t'({origin_y[15], origin_y});

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        fill_next       = fill_reg;
        left_next       = left_reg;
        item_valid_next = item_valid_reg;
        item_next       = item_reg;

        if (item_ready) begin
            item_valid_next = 1'b0;
        end

        if (accept) begin
            left_next = occupied;
            if (FW'(col_reg) >= fill_reg) begin
                fill_next = FW'(col_reg) + FW'(1);
            end
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end

            item_next.vert      = occupied != left_cell;
            item_next.horz      = occupied != below_cell;
            item_next.final_pos = col_end && row_end;
            item_next.x0        = ox + COORD_W'(col_reg);
            item_next.x1        = ox + COORD_W'(col_reg) + COORD_W'(1);
            item_next.y0        = oy + COORD_W'(row_reg);
            item_next.y1        = oy + COORD_W'(row_reg) + COORD_W'(1);
            item_valid_next     = (occupied != left_cell) || (occupied != below_cell);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            fill_reg       <= '0;
            left_reg       <= 1'b0;
            primed_reg     <= 1'b0;
            item_valid_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            fill_reg       <= fill_next;
            left_reg       <= left_next;
            primed_reg     <= !accept;
            item_valid_reg <= item_valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    `GOSE_ASSERT_NEXT(a_read_interlock, aclk, aresetn, accept, !s_tready)
    `GOSE_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, 32'(fill_reg) <= 32'(DEPTH))
    `GOSE_ASSERT_NEXT(a_item_held, aclk, aresetn, item_valid && !item_ready, item_valid)
    `GOSE_ASSERT_NOW(a_col_bound, aclk, aresetn, 1'b1, 32'(col_reg) <= 32'(MAX_COLUMNS))

endmodule

`default_nettype wire

/* sv/gose_emit.sv */
// gose_emit: holds one cell's segments and sends them as beats, vertical first
// uses gose_pkg
`default_nettype none
`include "grid_outline_segment_extractor_unit_assert.svh"

module gose_emit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             item_valid,
    input  wire gose_pkg::seg_item_t              item,
    output logic                                  item_ready,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // start_x, start_y, end_x, end_y, zero pad
    output logic [gose_pkg::M_TDATA_W-1:0]        m_tdata,
    // is_vertical, scan_done
    output logic [gose_pkg::M_TUSER_W-1:0]        m_tuser,
    output logic                                  m_tlast
);
    import gose_pkg::*;

    logic      vpend_reg, vpend_next;
    logic      hpend_reg, hpend_next;
    seg_item_t seg_reg, seg_next;
    logic      beat;
    coord_t    end_x, end_y;

    assign m_tvalid   = vpend_reg || hpend_reg;
    assign beat       = m_tvalid && m_tready;
    // free, or its last beat goes out now
    assign item_ready = !m_tvalid || (m_tready && (vpend_reg != hpend_reg));

    always_comb begin
        vpend_next = vpend_reg;
        hpend_next = hpend_reg;
        seg_next   = seg_reg;
        if (beat) begin
            if (vpend_reg) begin
                vpend_next = 1'b0;
            end else begin
                hpend_next = 1'b0;
            end
        end
        if (item_valid && item_ready) begin
            vpend_next = item.vert;
            hpend_next = item.horz;
            seg_next   = item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpend_reg <= 1'b0;
            hpend_reg <= 1'b0;
        end else begin
            vpend_reg <= vpend_next;
            hpend_reg <= hpend_next;
        end
        seg_reg <= seg_next;
    end

    assign end_x   = vpend_reg ? seg_reg.x0 : seg_reg.x1;
    assign end_y   = vpend_reg ? seg_reg.y1 : seg_reg.y0;
    assign m_tdata = {4'b0000, end_y, end_x, seg_reg.y0, seg_reg.x0};
    assign m_tuser = {seg_reg.final_pos, vpend_reg};
    assign m_tlast = !(vpend_reg && hpend_reg);

    `GOSE_ASSERT_NEXT(a_horz_follows, aclk, aresetn,
        beat && vpend_reg && hpend_reg, m_tvalid && !vpend_reg && hpend_reg)
    `GOSE_ASSERT_NOW(a_busy_blocks, aclk, aresetn, vpend_reg && hpend_reg, !item_ready)
    `GOSE_ASSERT_NOW(a_horz_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast)

endmodule

`default_nettype wire

/* sv/grid_outline_segment_extractor_unit.sv */
// Grid outline segment extractor. Cells of a binary grid arrive one per beat in raster
// order, columns 0..grid_columns then rows 0..grid_rows from the bottom, padding column
// and row supplied as zero by the caller. Each cell is compared with its left neighbor
// and with the cell below (held in a line buffer ram); a difference on the left gives a
// unit vertical segment, one below a unit horizontal segment, sent vertical first with
// tlast on the cell's final segment and scan_done on segments of the last position.
// After each accepted cell the block takes no new cell until the line buffer read for
// the next column is done, and a cell with two segments holds the result port until
// both are sent. Up to two cells are held while the result port is stalled. The line
// buffer needs no clearing pass after reset; columns not yet written read as empty. The
// user must write configuration through cfg_wr_en/cfg_addr/cfg_wr_data only while idle;
// the block does not enforce it. Uses gose_pkg, gose_scan, gose_emit and gose_ram.
`default_nettype none

module grid_outline_segment_extractor_unit #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gose_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [gose_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // occupied, zero pad
    input  wire logic [gose_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // start_x, start_y, end_x, end_y, zero pad
    output logic [gose_pkg::M_TDATA_W-1:0]         m_tdata,
    // is_vertical, scan_done
    output logic [gose_pkg::M_TUSER_W-1:0]         m_tuser,
    output logic                                   m_tlast
);
    import gose_pkg::*;

    logic signed [15:0] origin_x_reg, origin_x_next;
    logic signed [15:0] origin_y_reg, origin_y_next;
    logic        [6:0]  grid_columns_reg, grid_columns_next;
    logic        [6:0]  grid_rows_reg, grid_rows_next;

    logic      item_valid;
    logic      item_ready;
    seg_item_t item;

    always_comb begin
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        grid_columns_next = grid_columns_reg;
        grid_rows_next    = grid_rows_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_ORIGIN_X:     origin_x_next     = cfg_wr_data;
                CFG_ORIGIN_Y:     origin_y_next     = cfg_wr_data;
                CFG_GRID_COLUMNS: grid_columns_next = cfg_wr_data[6:0];
                CFG_GRID_ROWS:    grid_rows_next    = cfg_wr_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            grid_columns_reg <= 7'd1;
            grid_rows_reg    <= 7'd1;
        end else begin
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            grid_columns_reg <= grid_columns_next;
            grid_rows_reg    <= grid_rows_next;
        end
    end

    gose_scan #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .occupied     (s_tdata[0]),
        .item_valid   (item_valid),
        .item         (item),
        .item_ready   (item_ready)
    );

    gose_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* bench/tb_grid_outline_segment_extractor_unit.sv */
// tb_grid_outline_segment_extractor_unit: self-checking bench for the grid outline
// segment extractor; a directed table then random grids, all beats checked in order.
// Depends on gose_pkg and grid_outline_segment_extractor_unit only.
module tb_grid_outline_segment_extractor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gose_pkg::*;

    localparam int MAX_COLS       = 64;
    localparam int MAX_ROWS_CFG   = 64;
    localparam int RANDOM_CELLS   = 1300;
    localparam int CALM_TAIL      = 200;
    localparam int SETTLE_CYCLES  = 10;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic               vert;
        logic               last;
        logic               done;
    } segment_t;

    typedef struct packed {
        bit              is_cfg;
        cfg_reg_t        reg_sel;
        logic [15:0]     value;
        bit              occ;
        bit              typed;
        bit [1:0]        n_typed;
        segment_t        seg_a;
        segment_t        seg_b;
    } stim_row_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    grid_outline_segment_extractor_unit #(
        .MAX_COLUMNS(MAX_COLS),
        .MAX_ROWS   (MAX_ROWS_CFG)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // scan state and register copy of the outline predictor
    bit          below_line [0:MAX_COLS];
    bit          left_occ;
    int unsigned scan_col;
    int unsigned scan_row;
    logic [15:0] org_x;
    logic [15:0] org_y;
    logic [6:0]  cols_reg;
    logic [6:0]  rows_reg;

    segment_t  seg_expected [$];
    stim_row_t stim_rows [$];

    int  cells_sent;
    int  segs_checked;
    int  finals_seen;
    int  phases_run;
    int  mismatch_count;
    int  idle_cycles;
    int  rx_hold;
    bit  stall_on;
    bit  calm;

    function automatic int unsigned scan_limit(input logic [6:0] size, input int unsigned max);
        if (size == 0) return 1;
        if (size > max) return max;
        return size;
    endfunction

    function automatic logic [COORD_W-1:0] abs_coord(input logic [15:0] base,
                                                     input logic [COORD_W-1:0] offset);
        return {base[15], base} + offset;
    endfunction

    function automatic segment_t make_seg(input logic [COORD_W-1:0] sx, sy, ex, ey,
                                          input logic vert, last, done);
        segment_t s;
        s.sx   = sx;
        s.sy   = sy;
        s.ex   = ex;
        s.ey   = ey;
        s.vert = vert;
        s.last = last;
        s.done = done;
        return s;
    endfunction

    // appends one expected beat at the tail of the queue
    task automatic queue_seg(input segment_t s);
        seg_expected.insert(seg_expected.size(), s);
    endtask

    // one cell of the raster scan: up to two segments, vertical first
    task automatic step_scan(input bit occ, output int n, output segment_t s0, s1);
        int unsigned last_c;
        int unsigned last_r;
        int unsigned c;
        bit          lft;
        bit          blw;
        bit          fin;
        segment_t    h;
        last_c = scan_limit(cols_reg, MAX_COLS);
        last_r = scan_limit(rows_reg, MAX_ROWS_CFG);
        c   = (scan_col <= MAX_COLS) ? scan_col : MAX_COLS;
        lft = (c == 0) ? 1'b0 : left_occ;
        blw = (scan_row == 0) ? 1'b0 : below_line[c];
        fin = (c >= last_c) && (scan_row >= last_r);
        n  = 0;
        s0 = '0;
        s1 = '0;
        if (occ != lft) begin
            s0 = make_seg(abs_coord(org_x, COORD_W'(c)), abs_coord(org_y, COORD_W'(scan_row)),
                          abs_coord(org_x, COORD_W'(c)),
                          abs_coord(org_y, COORD_W'(scan_row + 1)), 1'b1, 1'b0, fin);
            n = 1;
        end
        if (occ != blw) begin
            h = make_seg(abs_coord(org_x, COORD_W'(c)), abs_coord(org_y, COORD_W'(scan_row)),
                         abs_coord(org_x, COORD_W'(c + 1)),
                         abs_coord(org_y, COORD_W'(scan_row)), 1'b0, 1'b0, fin);
            if (n == 0) s0 = h;
            else s1 = h;
            n++;
        end
        if (n == 1) s0.last = 1'b1;
        if (n == 2) s1.last = 1'b1;

        below_line[c] = occ;
        left_occ      = occ;
        if (c >= last_c) begin
            scan_col = 0;
            scan_row = (scan_row >= last_r) ? 0 : scan_row + 1;
        end else begin
            scan_col = c + 1;
        end
    endtask

    // drives one cell, waits for its beat, then queues what it should produce
    task automatic send_cell(input bit occ, input bit typed, input bit [1:0] n_typed,
                             input segment_t ta, tb);
        int       n;
        segment_t s0;
        segment_t s1;
        if (stall_on && !calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, occ};
        do @(posedge aclk); while (!s_tready);
        cells_sent++;
        step_scan(occ, n, s0, s1);
        if (typed) begin
            n  = n_typed;
            s0 = ta;
            s1 = tb;
        end
        if (n > 0) queue_seg(s0);
        if (n > 1) queue_seg(s1);
    endtask

    // cells without segments may still be in flight when the queue drains
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (seg_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // caller lowers cfg_wr_en after the last write of a burst
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_ORIGIN_X:     org_x    = value;
            CFG_ORIGIN_Y:     org_y    = value;
            CFG_GRID_COLUMNS: cols_reg = value[6:0];
            CFG_GRID_ROWS:    rows_reg = value[6:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic add_cfg(input cfg_reg_t idx, input logic [15:0] value);
        stim_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = idx;
        r.value   = value;
        stim_rows.insert(stim_rows.size(), r);
    endtask

    task automatic add_cell(input bit occ, input bit typed, input bit [1:0] n_typed,
                            input segment_t a, b);
        stim_row_t r;
        r         = '0;
        r.occ     = occ;
        r.typed   = typed;
        r.n_typed = n_typed;
        r.seg_a   = a;
        r.seg_b   = b;
        stim_rows.insert(stim_rows.size(), r);
    endtask

    // result side: random stall bursts on m_tready
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (aresetn && stall_on && !calm && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        segment_t got;
        segment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = make_seg(m_tdata[16:0], m_tdata[33:17], m_tdata[50:34], m_tdata[67:51],
                           m_tuser[0], m_tlast, m_tuser[1]);
            if (seg_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected beat: (%0d,%0d)-(%0d,%0d) vert %0b last %0b done %0b",
                             $signed(got.sx), $signed(got.sy), $signed(got.ex),
                             $signed(got.ey), got.vert, got.last, got.done);
            end else begin
                want = seg_expected.pop_front();
                segs_checked++;
                if (want.done) finals_seen++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: want (%0d,%0d)-(%0d,%0d) v%0b l%0b d%0b, ",
                                  "got (%0d,%0d)-(%0d,%0d) v%0b l%0b d%0b"},
                                 $signed(want.sx), $signed(want.sy), $signed(want.ex),
                                 $signed(want.ey), want.vert, want.last, want.done,
                                 $signed(got.sx), $signed(got.sy), $signed(got.ex),
                                 $signed(got.ey), got.vert, got.last, got.done);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d segments outstanding",
                     idle_cycles, seg_expected.size());
            $display("tb_grid_outline_segment_extractor_unit NOT OK");
            $finish;
        end
    end

    initial begin
        stim_row_t   row;
        int          directed_cells;
        int          count;
        int          density;
        bit          noise;
        bit          occ;
        bit          wrote;
        bit          pad;
        cfg_reg_t    r;
        logic [15:0] v;

        for (int i = 0; i <= MAX_COLS; i++) below_line[i] = 1'b0;
        left_occ = 1'b0;
        scan_col = 0;
        scan_row = 0;
        org_x    = '0;
        org_y    = '0;
        cols_reg = 7'd1;
        rows_reg = 7'd1;
        stall_on = 1'b1;
        calm     = 1'b0;

        // after reset: 1 by 1 grid at the origin, values read straight off the scan
        add_cell(1'b1, 1'b1, 2'd2, make_seg(0, 0, 0, 1, 1, 0, 0), make_seg(0, 0, 1, 0, 0, 1, 0));
        add_cell(1'b1, 1'b1, 2'd1, make_seg(1, 0, 2, 0, 0, 1, 0), '0);
        add_cell(1'b0, 1'b1, 2'd1, make_seg(0, 1, 1, 1, 0, 1, 0), '0);
        add_cell(1'b0, 1'b1, 2'd1, make_seg(1, 1, 2, 1, 0, 1, 1), '0);
        // wrapped to the corner, empty against empty: nothing comes out
        add_cell(1'b0, 1'b1, 2'd0, '0, '0);
        // origin extremes, largest grid
        add_cfg(CFG_ORIGIN_X, 16'h7FFF);
        add_cfg(CFG_ORIGIN_Y, 16'h8000);
        add_cfg(CFG_GRID_COLUMNS, 16'd64);
        add_cfg(CFG_GRID_ROWS, 16'd64);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        // zero width acts as one and cuts the current row short; rows above max clamp
        add_cfg(CFG_GRID_COLUMNS, 16'd0);
        add_cfg(CFG_GRID_ROWS, 16'd127);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        // zero height while above row 1: the end of the current row ends the scan
        add_cfg(CFG_ORIGIN_X, 16'h8000);
        add_cfg(CFG_ORIGIN_Y, 16'h7FFF);
        add_cfg(CFG_GRID_COLUMNS, 16'd1);
        add_cfg(CFG_GRID_ROWS, 16'd0);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);
        add_cfg(CFG_GRID_COLUMNS, 16'd127);
        add_cfg(CFG_GRID_ROWS, 16'd65);
        add_cell(1'b0, 1'b0, 2'd0, '0, '0);
        add_cell(1'b1, 1'b0, 2'd0, '0, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            if (row.is_cfg) begin
                if (i == 0 || !stim_rows[i-1].is_cfg) wait_idle();
                write_reg(row.reg_sel, row.value);
                if (i + 1 == stim_rows.size() || !stim_rows[i+1].is_cfg) cfg_wr_en <= 1'b0;
            end else begin
                send_cell(row.occ, row.typed, row.n_typed, row.seg_a, row.seg_b);
            end
        end
        directed_cells = cells_sent;

        while (cells_sent < directed_cells + RANDOM_CELLS) begin
            wait_idle();
            calm  = (cells_sent >= directed_cells + RANDOM_CELLS - CALM_TAIL);
            wrote = 1'b0;
            for (int i = 0; i < 4; i++) begin
                r = cfg_reg_t'(i);
                if ($urandom_range(0, 1) == 0 || (r == CFG_GRID_ROWS && !wrote)) begin
                    if (r == CFG_ORIGIN_X || r == CFG_ORIGIN_Y) begin
                        case ($urandom_range(0, 7))
                            0:       v = 16'h7FFF;
                            1:       v = 16'h8000;
                            2:       v = 16'h0000;
                            3:       v = 16'hFFFF;
                            default: v = 16'($urandom);
                        endcase
                    end else begin
                        // mostly small grids, now and then the edges of the size range
                        case ($urandom_range(0, 15))
                            0:       v = 16'd0;
                            1:       v = 16'd64;
                            2:       v = 16'($urandom_range(65, 127));
                            3:       v = 16'd1;
                            default: v = 16'($urandom_range(1, 6));
                        endcase
                        if ($urandom_range(0, 3) == 0) v[15:7] = 9'($urandom);
                    end
                    write_reg(r, v);
                    wrote = 1'b1;
                end
            end
            cfg_wr_en <= 1'b0;
            phases_run++;

            stall_on = ($urandom_range(0, 3) != 0);
            noise    = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 4))
                0:       density = 0;
                1:       density = 100;
                2:       density = 25;
                3:       density = 75;
                default: density = 50;
            endcase
            count = $urandom_range(10, 120);
            repeat (count) begin
                pad = (scan_col >= scan_limit(cols_reg, MAX_COLS)) ||
                      (scan_row >= scan_limit(rows_reg, MAX_ROWS_CFG));
                occ = ($urandom_range(0, 99) < density);
                // well-formed grids keep the padding column and row empty
                if (pad && !noise && $urandom_range(0, 9) != 0) occ = 1'b0;
                send_cell(occ, 1'b0, 2'd0, '0, '0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (seg_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d cells over %0d register settings, %0d segments checked",
                 cells_sent, phases_run, segs_checked);
        $display("%0d segments carried end of scan, %0d mismatches", finals_seen, mismatch_count);
        if (mismatch_count == 0 && seg_expected.size() == 0) begin
            $display("tb_grid_outline_segment_extractor_unit OK");
        end else begin
            $display("tb_grid_outline_segment_extractor_unit NOT OK");
        end
        $finish;
    end

endmodule

/* grid_outline_segment_extractor_unit.f */
+incdir+sv
sv/gose_pkg.sv
sv/gose_ram.sv
sv/gose_scan.sv
sv/gose_emit.sv
sv/grid_outline_segment_extractor_unit.sv
bench/tb_grid_outline_segment_extractor_unit.sv
